@@ rtl/core/wrrts_pkg.sv @@
// Shared types and constants for the weighted round-robin task scheduler.
// Used by wrrts_ctrl, wrrts_dp and the top level; depends on nothing.
`default_nettype none

package wrrts_pkg;

    // Field widths of the stream items
    localparam int FUNC_W     = 2;
    localparam int TS_W       = 64;
    localparam int PRIO_W     = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int STATUS_W   = 2;

    // Input tdata layout: now, priority_req, kill_id, delay_cycles
    localparam int NOW_LSB     = 0;
    localparam int PRIO_LSB    = NOW_LSB + TS_W;
    localparam int KILL_LSB    = PRIO_LSB + PRIO_W;
    localparam int DELAY_LSB   = KILL_LSB + TS_W;
    localparam int S_TDATA_W   = DELAY_LSB + TS_W;

    // Output tdata layout: current_slot, created_id, status, zero pad
    localparam int M_FIELDS_W  = 2 * SLOT_OUT_W + STATUS_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_CREATE = 2'd1,
        FUNC_KILL   = 2'd2,
        FUNC_DELAY  = 2'd3
    } func_e_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK   = 2'd0,
        STS_FULL = 2'd1,
        STS_NONE = 2'd2,
        STS_HALT = 2'd3
    } status_e_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_QREAD,
        S_SCAN,
        S_DONE
    } state_e_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      capture;
        logic      create;
        logic      kill;
        logic      delay;
        logic      q_read;
        logic      q_write;
        logic      scan_start;
        logic      scan_step;
        logic      res_write;
        status_e_t res_status;
        logic      out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        func_e_t func;
        logic    empty;
        logic    full;
        logic    kill_hit;
        logic    kill_cur;
        logic    q_zero;
        logic    scan_hit;
        logic    scan_last;
        logic    out_busy;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/wrrts_ctrl.sv @@
// Sequencing state machine of the task scheduler.
// Depends on wrrts_pkg; drives wrrts_dp through cmd_t and reads stat_t.
`default_nettype none

module wrrts_ctrl
    import wrrts_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_e_t state_reg;
    state_e_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.res_write = 1'b1;
                state_next    = S_DONE;
                case (stat.func)
                    FUNC_TICK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = STS_NONE;
                        end
                        else
                        begin
                            cmd.res_write = 1'b0;
                            cmd.q_read    = 1'b1;
                            state_next    = S_QREAD;
                        end
                    end
                    FUNC_CREATE:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status = STS_FULL;
                        end
                        else
                        begin
                            cmd.create     = 1'b1;
                            cmd.res_status = STS_OK;
                        end
                    end
                    FUNC_KILL:
                    begin
                        cmd.kill       = stat.kill_hit;
                        cmd.res_status = (stat.kill_hit && stat.kill_cur) ? STS_HALT : STS_OK;
                    end
                    FUNC_DELAY:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = STS_NONE;
                        end
                        else
                        begin
                            cmd.delay      = 1'b1;
                            cmd.res_status = STS_OK;
                        end
                    end
                    default:
                    begin
                        cmd.res_status = STS_OK;
                    end
                endcase
            end
            S_QREAD:
            begin
                // Spend one unit, or reload and start the round-robin scan
                cmd.q_write = 1'b1;
                if (!stat.q_zero)
                begin
                    cmd.res_write  = 1'b1;
                    cmd.res_status = STS_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                begin
                    cmd.res_write  = 1'b1;
                    cmd.res_status = STS_OK;
                    state_next     = S_DONE;
                end
                else if (stat.scan_last)
                begin
                    cmd.res_write  = 1'b1;
                    cmd.res_status = STS_NONE;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A result is loaded only when the output register can take it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !stat.out_busy)
        else $error("result loaded over a pending transfer");

    // After a capture the controller leaves idle and stops taking items
    a_take_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !in_ready)
        else $error("capture did not leave idle");

    // A scan never starts unless the quantum was found spent
    a_scan_after_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |-> stat.q_zero)
        else $error("scan started with quantum left");

endmodule

`default_nettype wire

@@ rtl/core/wrrts_dp.sv @@
// Datapath of the task scheduler: slot flags, quantum and wake-time memories,
// scan pointer and the output register. Depends on wrrts_pkg.
`default_nettype none

module wrrts_dp
    import wrrts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [S_TDATA_W-1:0] in_data,
    input  wire logic [FUNC_W-1:0]    in_func,
    input  wire cmd_t                 cmd,
    output stat_t                     stat,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [M_TDATA_W-1:0]      out_data
);

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int QP_W   = 2 * PRIO_W;

    // Captured item
    func_e_t           func_reg;
    logic [TS_W-1:0]   now_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [TS_W-1:0]   kill_id_reg;
    logic [TS_W-1:0]   delay_reg;

    // Scheduler state
    logic [TASK_SLOTS-1:0] valid_reg, valid_next;
    logic [TASK_SLOTS-1:0] blocked_reg, blocked_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [SLOT_W-1:0]     running_reg, running_next;
    logic [SLOT_W-1:0]     created_reg, created_next;
    logic [SLOT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    status_e_t             status_reg;

    // Memories: {priority, quantum left} and wake time per slot
    logic [QP_W-1:0]  qp_mem [TASK_SLOTS];
    logic [TS_W-1:0]  wake_mem [TASK_SLOTS];
    logic [QP_W-1:0]  qp_rd_reg;
    logic [TS_W-1:0]  wake_rd_reg;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [SLOT_W-1:0] used_idx;
    logic [SLOT_W-1:0] kill_idx;
    logic [SLOT_W-1:0] nxt_run;
    logic [SLOT_W-1:0] nxt_pos;
    logic [SLOT_W-1:0] wake_raddr;
    logic [PRIO_W-1:0] q_prio;
    logic [PRIO_W-1:0] q_left;
    logic              wake_due;
    logic              runnable;
    logic              out_busy;

    assign used_idx = used_reg[SLOT_W-1:0];
    assign kill_idx = kill_id_reg[SLOT_W-1:0];
    assign q_prio   = qp_rd_reg[QP_W-1:PRIO_W];
    assign q_left   = qp_rd_reg[PRIO_W-1:0];

    // Round-robin successor within the used slots
    assign nxt_run = (CNT_W'(running_reg) == used_reg - CNT_W'(1)) ? '0
                     : running_reg + SLOT_W'(1);
    assign nxt_pos = (CNT_W'(pos_reg) == used_reg - CNT_W'(1)) ? '0
                     : pos_reg + SLOT_W'(1);
    assign wake_raddr = cmd.scan_start ? nxt_run : nxt_pos;

    // Slot under scan: wake it if due, take it if valid and not blocked
    assign wake_due = blocked_reg[pos_reg] && (now_reg >= wake_rd_reg);
    assign runnable = valid_reg[pos_reg] && (!blocked_reg[pos_reg] || wake_due);

    assign out_busy = out_valid_reg && !out_ready;

    // Status toward the controller
    always_comb
    begin
        stat.func      = func_reg;
        stat.empty     = (used_reg == '0) || (CNT_W'(running_reg) >= used_reg);
        stat.full      = (used_reg == CNT_W'(TASK_SLOTS));
        stat.kill_hit  = (kill_id_reg[TS_W-1:CNT_W] == '0)
                         && (kill_id_reg[CNT_W-1:0] < used_reg);
        stat.kill_cur  = (kill_idx == running_reg);
        stat.q_zero    = (q_left == '0);
        stat.scan_hit  = runnable;
        stat.scan_last = (scan_cnt_reg == used_reg - CNT_W'(1));
        stat.out_busy  = out_busy;
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= func_e_t'(in_func);
            now_reg     <= in_data[NOW_LSB +: TS_W];
            prio_reg    <= in_data[PRIO_LSB +: PRIO_W];
            kill_id_reg <= in_data[KILL_LSB +: TS_W];
            delay_reg   <= in_data[DELAY_LSB +: TS_W];
        end
    end

    // Next values of the slot flags, counters and pointers
    always_comb
    begin
        valid_next    = valid_reg;
        blocked_next  = blocked_reg;
        used_next     = used_reg;
        running_next  = running_reg;
        created_next  = created_reg;
        pos_next      = pos_reg;
        scan_cnt_next = scan_cnt_reg;
        if (cmd.capture)
        begin
            created_next = '0;
        end
        if (cmd.create)
        begin
            valid_next[used_idx]   = 1'b1;
            blocked_next[used_idx] = 1'b0;
            used_next              = used_reg + CNT_W'(1);
            created_next           = used_idx;
            if (used_reg == '0)
            begin
                running_next = '0;
            end
        end
        if (cmd.kill)
        begin
            valid_next[kill_idx] = 1'b0;
        end
        if (cmd.delay)
        begin
            blocked_next[running_reg] = 1'b1;
        end
        if (cmd.scan_start)
        begin
            pos_next      = nxt_run;
            scan_cnt_next = '0;
        end
        if (cmd.scan_step)
        begin
            if (wake_due)
            begin
                blocked_next[pos_reg] = 1'b0;
            end
            if (runnable)
            begin
                running_next = pos_reg;
            end
            else
            begin
                pos_next      = nxt_pos;
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            blocked_reg   <= '0;
            used_reg      <= '0;
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            blocked_reg   <= blocked_next;
            used_reg      <= used_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        created_reg  <= created_next;
        pos_reg      <= pos_next;
        scan_cnt_reg <= scan_cnt_next;
        if (cmd.res_write)
        begin
            status_reg <= cmd.res_status;
        end
    end

    // Quantum memory: one write port, registered read at the running slot
    always_ff @(posedge clk)
    begin
        if (cmd.create)
        begin
            qp_mem[used_idx] <= {prio_reg, prio_reg};
        end
        else if (cmd.q_write)
        begin
            qp_mem[running_reg] <= {q_prio, stat.q_zero ? q_prio : q_left - PRIO_W'(1)};
        end
        if (cmd.q_read)
        begin
            qp_rd_reg <= qp_mem[running_reg];
        end
    end

    // Wake-time memory: written on delay, read one slot ahead of the scan
    always_ff @(posedge clk)
    begin
        if (cmd.delay)
        begin
            wake_mem[running_reg] <= now_reg + delay_reg;
        end
        if (cmd.scan_start || cmd.scan_step)
        begin
            wake_rd_reg <= wake_mem[wake_raddr];
        end
    end

    // Output register: load a result, drop it once transferred
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {{M_PAD_W{1'b0}}, status_reg,
                             SLOT_OUT_W'(created_reg), SLOT_OUT_W'(running_reg)};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // While any slot is used, the running slot is one of them
    a_running_used: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != '0) |-> (CNT_W'(running_reg) < used_reg))
        else $error("running slot outside the used slots");

    // The table never grows past its size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TASK_SLOTS))
        else $error("slot count beyond table size");

    // The scan visits at most every used slot once
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (scan_cnt_reg < used_reg) && (CNT_W'(pos_reg) < used_reg))
        else $error("scan ran past the used slots");

endmodule

`default_nettype wire

@@ rtl/core/weighted_round_robin_task_scheduler_unit.sv @@
// Top level of the weighted round-robin task scheduler.
// Depends on wrrts_pkg, wrrts_ctrl and wrrts_dp.
//
// Channel  Dir  Signals                 Contents (low bit up)
// s_axis   in   tvalid tready tdata     now, priority_req, kill_id, delay_cycles
//                              tuser    func
// m_axis   out  tvalid tready tdata     current_slot, created_id, status, zero pad
//
// Create, kill and delay step through idle, exec and done; the result loads from done once
// the output register is free. A tick that only spends quantum also passes through qread.
// A tick that reloads the quantum adds the scan state, visiting each used slot at most once,
// at most TASK_SLOTS, the scan stepping through the wake-time memory one slot per cycle.
// rst_n clears all slot flags, the slot count and the running slot at once.
// A stalled result waits in the output register; the next item is taken after it loads.
`default_nettype none

module weighted_round_robin_task_scheduler_unit
    import wrrts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // now[63:0], priority_req[71:64], kill_id[135:72], delay_cycles[199:136]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // func[1:0]
    input  wire logic [FUNC_W-1:0]    s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // current_slot[3:0], created_id[7:4], status[9:8], zero[15:10]
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    cmd_t  cmd;
    stat_t stat;

    wrrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wrrts_dp #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_func   (s_axis_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for weighted_round_robin_task_scheduler_unit.
// Drives commands over the input stream and checks each result against an in-bench scheduler
// model. Depends on wrrts_pkg and the scheduler RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wrrts_pkg::*;

    localparam int TASK_SLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [3:0] current_slot;
        logic [3:0] created_id;
        status_e_t  status;
    } grant_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [FUNC_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Scheduler model state
    bit          task_live [TASK_SLOTS];
    bit          task_blocked [TASK_SLOTS];
    logic [7:0]  task_prio [TASK_SLOTS];
    logic [7:0]  task_quantum [TASK_SLOTS];
    logic [63:0] task_wake [TASK_SLOTS];
    int unsigned slots_taken;
    int unsigned run_slot;

    grant_t      pending_grants[$];
    logic [63:0] wall_clock;
    bit          idle_on;
    bit          failed;
    int          cycle_count;

    weighted_round_robin_task_scheduler_unit #(
        .TASK_SLOTS(TASK_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one command to the scheduler model and return the result it produces
    task automatic schedule_step(input func_e_t f, input logic [63:0] t, input logic [7:0] p,
                                 input logic [63:0] kid, input logic [63:0] dly,
                                 output grant_t g);
        int unsigned pos;
        int unsigned n;
        bit          found;
        g.created_id = 4'd0;
        g.status     = STS_OK;
        case (f)
            FUNC_TICK:
            begin
                if (slots_taken == 0)
                    g.status = STS_NONE;
                else if (task_quantum[run_slot] != 8'd0)
                    task_quantum[run_slot] = task_quantum[run_slot] - 8'd1;
                else
                begin
                    // Reload the quantum, then scan round-robin from the next slot
                    task_quantum[run_slot] = task_prio[run_slot];
                    pos   = run_slot;
                    found = 1'b0;
                    for (n = 0; n < slots_taken && !found; n++)
                    begin
                        pos = (pos + 1 >= slots_taken) ? 0 : pos + 1;
                        if (task_blocked[pos] && t >= task_wake[pos])
                        begin
                            task_blocked[pos] = 1'b0;
                            task_wake[pos]    = 64'd0;
                        end
                        if (task_live[pos] && !task_blocked[pos])
                        begin
                            run_slot = pos;
                            found    = 1'b1;
                        end
                    end
                    if (!found)
                        g.status = STS_NONE;
                end
            end
            FUNC_CREATE:
            begin
                if (slots_taken >= TASK_SLOTS)
                    g.status = STS_FULL;
                else
                begin
                    task_live[slots_taken]    = 1'b1;
                    task_blocked[slots_taken] = 1'b0;
                    task_prio[slots_taken]    = p;
                    task_quantum[slots_taken] = p;
                    task_wake[slots_taken]    = 64'd0;
                    if (slots_taken == 0)
                        run_slot = 0;
                    g.created_id = slots_taken[3:0];
                    slots_taken  = slots_taken + 1;
                end
            end
            FUNC_KILL:
            begin
                // Ids past the used slots are ignored
                if (kid < 64'(slots_taken))
                begin
                    task_live[kid[3:0]] = 1'b0;
                    if (kid == 64'(run_slot))
                        g.status = STS_HALT;
                end
            end
            default:
            begin
                if (slots_taken == 0)
                    g.status = STS_NONE;
                else
                begin
                    task_wake[run_slot]    = t + dly;
                    task_blocked[run_slot] = 1'b1;
                end
            end
        endcase
        g.current_slot = run_slot[3:0];
    endtask

    // Drop tvalid and hold the input side idle
    task automatic hold_off(input int n);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Offer one command and record its expected result once the transfer happens
    task automatic send_cmd(input func_e_t f, input logic [63:0] t, input logic [7:0] p,
                            input logic [63:0] kid, input logic [63:0] dly);
        grant_t g;
        if (idle_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 11));
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dly, kid, p, t};
        s_axis_tuser  <= f;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        schedule_step(f, t, p, kid, dly, g);
        pending_grants.push_back(g);
    endtask

    task automatic wait_drained();
        hold_off(1);
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    // Tick, delay and kill with no tasks created yet
    task automatic test_empty_table();
        send_cmd(FUNC_TICK, 64'd0, 8'd0, 64'd0, 64'd0);
        send_cmd(FUNC_DELAY, 64'd5, 8'd0, 64'd0, 64'd7);
        send_cmd(FUNC_KILL, 64'd6, 8'd0, 64'd0, 64'd0);
    endtask

    // First task, priority extremes, kills, wrapped wake time and an all-blocked scan
    task automatic test_first_tasks();
        send_cmd(FUNC_CREATE, 64'd8, 8'd0, 64'd0, 64'd0);
        send_cmd(FUNC_TICK, 64'd10, 8'd0, 64'd0, 64'd0);
        send_cmd(FUNC_CREATE, 64'd12, 8'hFF, 64'd0, 64'd0);
        send_cmd(FUNC_KILL, 64'd14, 8'd0, 64'd1, 64'd0);
        send_cmd(FUNC_CREATE, 64'd16, 8'd1, 64'd0, 64'd0);
        send_cmd(FUNC_DELAY, 64'd100, 8'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(FUNC_TICK, 64'd200, 8'd0, 64'd0, 64'd0);
        send_cmd(FUNC_KILL, 64'd205, 8'd0, 64'd2, 64'd0);
        send_cmd(FUNC_TICK, 64'd210, 8'd0, 64'd0, 64'd0);
        send_cmd(FUNC_TICK, 64'd220, 8'd0, 64'd0, 64'd0);
        send_cmd(FUNC_DELAY, 64'd300, 8'd0, 64'd0, 64'd1000);
        send_cmd(FUNC_TICK, 64'd310, 8'd0, 64'd0, 64'd0);
        send_cmd(FUNC_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 64'd0, 64'd0);
        send_cmd(FUNC_KILL, 64'd320, 8'd0, 64'h8000_0000_0000_0003, 64'd0);
    endtask

    // Mostly ticks on a rising clock, with creates, delays, kills and junk in unused fields
    task automatic test_random_mix(input int count);
        int          i;
        int          pick;
        func_e_t     f;
        logic [63:0] t;
        logic [63:0] kid;
        logic [63:0] dly;
        logic [7:0]  p;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            p    = 8'($urandom);
            kid  = {$urandom, $urandom};
            dly  = {$urandom, $urandom};
            if (pick < 6)
            begin
                f = FUNC_CREATE;
                if ($urandom_range(0, 7) != 0)
                    p = 8'($urandom_range(0, 4));
            end
            else if (pick < 8)
            begin
                f = FUNC_KILL;
                case ($urandom_range(0, 3))
                    0, 1: kid = 64'($urandom_range(0, 15));
                    2: kid = 64'($urandom_range(16, 300));
                    default: ;
                endcase
            end
            else if (pick < 20)
            begin
                f = FUNC_DELAY;
                if ($urandom_range(0, 9) != 0)
                    dly = 64'($urandom_range(0, 300));
            end
            else
                f = FUNC_TICK;
            // Occasionally jump the timestamp anywhere, otherwise advance it
            if ($urandom_range(0, 19) == 0)
                t = {$urandom, $urandom};
            else
            begin
                wall_clock = wall_clock + 64'($urandom_range(1, 30));
                t = wall_clock;
            end
            send_cmd(f, t, p, kid, dly);
        end
    endtask

    // Hold the run until every outstanding result has been received
    task automatic test_drain_pause();
        wait_drained();
    endtask

    // Result side: random stall bursts while idling is enabled
    initial
    begin : result_stall
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 11);
            m_axis_tready <= (stall_left == 0);
        end
    end

    // Compare each result transfer with the oldest expected result
    always @(posedge clk)
    begin : check_result
        grant_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tdata %h",
                         $time, m_axis_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (m_axis_tdata[3:0] !== want.current_slot)
                begin
                    $display("%0t: current_slot mismatch, expected %0d, actual %0d",
                             $time, want.current_slot, m_axis_tdata[3:0]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[7:4] !== want.created_id)
                begin
                    $display("%0t: created_id mismatch, expected %0d, actual %0d",
                             $time, want.created_id, m_axis_tdata[7:4]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[9:8] !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_axis_tdata[9:8]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on total run length
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("weighted_round_robin_task_scheduler_unit test failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_TICK;
        idle_on       = 1'b1;
        failed        = 1'b0;
        slots_taken   = 0;
        run_slot      = 0;
        wall_clock    = 64'd1000;
        for (int k = 0; k < TASK_SLOTS; k++)
        begin
            task_live[k]    = 1'b0;
            task_blocked[k] = 1'b0;
            task_prio[k]    = 8'd0;
            task_quantum[k] = 8'd0;
            task_wake[k]    = 64'd0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_first_tasks();
        test_random_mix(450);
        test_drain_pause();
        test_random_mix(350);
        idle_on = 1'b0;
        test_random_mix(180);

        // Let the last results arrive, then wait before reporting
        wait_drained();
        repeat (40) @(posedge clk);
        if (!failed)
            $display("weighted_round_robin_task_scheduler_unit test passed");
        else
            $display("weighted_round_robin_task_scheduler_unit test failed");
        $finish;
    end

endmodule
